// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on rising clk, suspended while rst is high.
`define PIP_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");
// Checked on every rising clk, reset included.
`define PIP_ASSERT_ALL(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) else $error("assertion failed");
`else
`define PIP_ASSERT(lbl, clk_s, rst_s, prop)
`define PIP_ASSERT_ALL(lbl, clk_s, prop)
`endif
`endif

// ----- hw/rtl/pip_pkg.sv -----
package pip_pkg;

  localparam int MAX_EDGES  = 8;
  localparam int COORD_BITS = 24;
  localparam int NORM_BITS  = 13;

  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);

  localparam int SLOT_W = 3;
  localparam int ECFG_W = 4;
  localparam int NRM_W  = 18;
  localparam int COS_W  = 17;
  localparam int CFG_W  = 18;
  localparam int CIDX_W = 3;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int CROSS_W = 2 * COORD_BITS + 2;
  localparam int MAG_W   = 2 * COORD_BITS + 1;
  localparam int CV_W    = NORM_BITS + 1;
  localparam int DOT_W   = CV_W + NRM_W + 1;
  localparam int CSQ_W   = 2 * NORM_BITS + 2;
  localparam int MUL_W   = (DIFF_W > DOT_W) ? DIFF_W : DOT_W;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CMP_W   = 2 * (DOT_W - 1);

  localparam int LIM_SHIFT    = 16;
  localparam int COARSE_SHIFT = 8;

  localparam int STEP_W     = 3;
  localparam int LAST_MSTEP = 6;

  localparam logic [CIDX_W-1:0] REG_EDGE_COUNT = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] REG_NORMAL_X   = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] REG_NORMAL_Y   = CIDX_W'(2);
  localparam logic [CIDX_W-1:0] REG_NORMAL_Z   = CIDX_W'(3);
  localparam logic [CIDX_W-1:0] REG_COS_SQ     = CIDX_W'(4);

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  localparam logic [ECFG_W-1:0]       EDGE_COUNT_RST = ECFG_W'(5);
  localparam logic signed [NRM_W-1:0] NORMAL_XY_RST  = NRM_W'(0);
  localparam logic signed [NRM_W-1:0] NORMAL_Z_RST   = NRM_W'(65536);
  localparam logic [COS_W-1:0]        COS_SQ_RST     = COS_W'(63560);

endpackage

// ----- hw/rtl/pip_mul.sv -----
// Shared signed multiplier, product registered.
module pip_mul import pip_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ----- hw/rtl/point_in_convex_polygon_test_core.sv -----
// Point-in-convex-polygon test. A load request (func 0) stores one edge, a corner and a
// direction, into a slot and returns nothing. A test request (func 1) walks the first
// min(edge_count, MAX_EDGES) edges in order and returns one inside_res bit: for each edge
// c = direction x (point - corner) must lie within the cone around the configured normal
// (or be zero); the walk stops at the first failing edge. All multiplications run through
// one registered multiplier under a small sequencer. Magnitude scaling takes one step of
// 8 or 1 bits per cycle; an edge with a zero cross product passes without scaling, and a
// failing edge ends the walk sooner than a passing one. A test with no edges answers 1
// without fetching any edge. The input is not ready while a test runs; the result sits in
// an output register, and a finished test waits there only if the previous result is
// still untaken. Slots read before they were ever loaded give unspecified results.
`include "assert_macros.svh"

module point_in_convex_polygon_test_core import pip_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CIDX_W-1:0]            cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         func,
  input  logic [SLOT_W-1:0]            slot,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [COORD_BITS-1:0] dir_x,
  input  logic signed [COORD_BITS-1:0] dir_y,
  input  logic signed [COORD_BITS-1:0] dir_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         inside_res
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DIFF, S_CROSS, S_ABS, S_NORM, S_DOT, S_SQ, S_NEXT, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [ECFG_W-1:0]       edge_count;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [COS_W-1:0]        cos_sq_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count   <= EDGE_COUNT_RST;
      normal_x     <= NORMAL_XY_RST;
      normal_y     <= NORMAL_XY_RST;
      normal_z     <= NORMAL_Z_RST;
      cos_sq_limit <= COS_SQ_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EDGE_COUNT: edge_count   <= cfg_data[ECFG_W-1:0];
        REG_NORMAL_X:   normal_x     <= cfg_data[NRM_W-1:0];
        REG_NORMAL_Y:   normal_y     <= cfg_data[NRM_W-1:0];
        REG_NORMAL_Z:   normal_z     <= cfg_data[NRM_W-1:0];
        REG_COS_SQ:     cos_sq_limit <= cfg_data[COS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ECNT_W-1:0] n_lim;
  assign n_lim = (int'(edge_count) > MAX_EDGES) ? ECNT_W'(MAX_EDGES) : ECNT_W'(edge_count);

  // edge store
  logic signed [COORD_BITS-1:0] corner_mem [MAX_EDGES][3];
  logic signed [COORD_BITS-1:0] dir_mem    [MAX_EDGES][3];
  logic signed [COORD_BITS-1:0] corner_rd  [3];
  logic signed [COORD_BITS-1:0] dir_rd     [3];
  logic [ECNT_W-1:0]            eidx;
  logic                         load_we;

  assign in_ready = (state == S_IDLE);
  assign load_we  = in_valid && in_ready && (func == FUNC_LOAD) && (int'(slot) < MAX_EDGES);

  always_ff @(posedge clk) begin
    if (load_we) begin
      corner_mem[EIDX_W'(slot)][0] <= point_x;
      corner_mem[EIDX_W'(slot)][1] <= point_y;
      corner_mem[EIDX_W'(slot)][2] <= point_z;
      dir_mem[EIDX_W'(slot)][0]    <= dir_x;
      dir_mem[EIDX_W'(slot)][1]    <= dir_y;
      dir_mem[EIDX_W'(slot)][2]    <= dir_z;
    end
    if (state == S_FETCH) begin
      for (int j = 0; j < 3; j++) begin
        corner_rd[j] <= corner_mem[eidx[EIDX_W-1:0]][j];
        dir_rd[j]    <= dir_mem[eidx[EIDX_W-1:0]][j];
      end
    end
  end

  // datapath registers
  logic signed [COORD_BITS-1:0] pt    [3];
  logic signed [DIFF_W-1:0]     ev    [3];
  logic signed [CROSS_W-1:0]    cr    [3];
  logic [MAG_W-1:0]             mag   [3];
  logic                         sgn   [3];
  logic signed [CV_W-1:0]       cv    [3];
  logic signed [DOT_W-1:0]      dot;
  logic [CSQ_W-1:0]             csq;
  logic [CMP_W-1:0]             dsq;
  logic [ECNT_W-1:0]            edge_lim;
  logic [STEP_W-1:0]            cnt;
  logic                         res;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  pip_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  logic [MAG_W-1:0] mag_or;
  logic             coarse_hi;
  logic             fine_hi;
  logic [CMP_W-1:0] lim;

  assign mag_or    = mag[0] | mag[1] | mag[2];
  assign coarse_hi = |mag_or[MAG_W-1:NORM_BITS+COARSE_SHIFT];
  assign fine_hi   = |mag_or[MAG_W-1:NORM_BITS];
  assign lim       = prod[CMP_W-1:0] << LIM_SHIFT;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_CROSS: begin
        case (cnt)
          3'd0: begin mul_a = MUL_W'(dir_rd[1]); mul_b = MUL_W'(ev[2]); end
          3'd1: begin mul_a = MUL_W'(dir_rd[2]); mul_b = MUL_W'(ev[1]); end
          3'd2: begin mul_a = MUL_W'(dir_rd[2]); mul_b = MUL_W'(ev[0]); end
          3'd3: begin mul_a = MUL_W'(dir_rd[0]); mul_b = MUL_W'(ev[2]); end
          3'd4: begin mul_a = MUL_W'(dir_rd[0]); mul_b = MUL_W'(ev[1]); end
          3'd5: begin mul_a = MUL_W'(dir_rd[1]); mul_b = MUL_W'(ev[0]); end
          default: ;
        endcase
      end
      S_DOT: begin
        case (cnt)
          3'd0: begin mul_a = MUL_W'(cv[0]); mul_b = MUL_W'(normal_x); end
          3'd1: begin mul_a = MUL_W'(cv[1]); mul_b = MUL_W'(normal_y); end
          3'd2: begin mul_a = MUL_W'(cv[2]); mul_b = MUL_W'(normal_z); end
          3'd3: begin
            mul_a = MUL_W'(mag[0][NORM_BITS-1:0]);
            mul_b = MUL_W'(mag[0][NORM_BITS-1:0]);
          end
          3'd4: begin
            mul_a = MUL_W'(mag[1][NORM_BITS-1:0]);
            mul_b = MUL_W'(mag[1][NORM_BITS-1:0]);
          end
          3'd5: begin
            mul_a = MUL_W'(mag[2][NORM_BITS-1:0]);
            mul_b = MUL_W'(mag[2][NORM_BITS-1:0]);
          end
          default: ;
        endcase
      end
      S_SQ: begin
        case (cnt)
          3'd0: begin mul_a = MUL_W'(dot); mul_b = MUL_W'(dot); end
          3'd1: begin mul_a = MUL_W'(cos_sq_limit); mul_b = MUL_W'(csq); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && func == FUNC_TEST) begin
            pt[0]    <= point_x;
            pt[1]    <= point_y;
            pt[2]    <= point_z;
            edge_lim <= n_lim;
            eidx     <= '0;
            if (n_lim == '0) begin
              res   <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          for (int j = 0; j < 3; j++) begin
            ev[j] <= DIFF_W'(pt[j]) - DIFF_W'(corner_rd[j]);
          end
          cnt   <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          // product of step k lands in the cycle after it is issued
          case (cnt)
            3'd1: cr[0] <= prod[CROSS_W-1:0];
            3'd2: cr[0] <= cr[0] - prod[CROSS_W-1:0];
            3'd3: cr[1] <= prod[CROSS_W-1:0];
            3'd4: cr[1] <= cr[1] - prod[CROSS_W-1:0];
            3'd5: cr[2] <= prod[CROSS_W-1:0];
            3'd6: cr[2] <= cr[2] - prod[CROSS_W-1:0];
            default: ;
          endcase
          if (cnt == STEP_W'(LAST_MSTEP)) begin
            state <= S_ABS;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ABS: begin
          for (int j = 0; j < 3; j++) begin
            sgn[j] <= cr[j][CROSS_W-1];
            mag[j] <= MAG_W'(cr[j][CROSS_W-1] ? -cr[j] : cr[j]);
          end
          state <= S_NORM;
        end
        S_NORM: begin
          if (mag_or == '0) begin
            state <= S_NEXT;
          end else if (coarse_hi) begin
            for (int j = 0; j < 3; j++) mag[j] <= mag[j] >> COARSE_SHIFT;
          end else if (fine_hi) begin
            for (int j = 0; j < 3; j++) mag[j] <= mag[j] >> 1;
          end else begin
            for (int j = 0; j < 3; j++) begin
              cv[j] <= sgn[j] ? -$signed(mag[j][CV_W-1:0]) : $signed(mag[j][CV_W-1:0]);
            end
            cnt   <= '0;
            state <= S_DOT;
          end
        end
        S_DOT: begin
          case (cnt)
            3'd1: dot <= prod[DOT_W-1:0];
            3'd2: dot <= dot + prod[DOT_W-1:0];
            3'd3: dot <= dot + prod[DOT_W-1:0];
            3'd4: csq <= prod[CSQ_W-1:0];
            3'd5: csq <= csq + prod[CSQ_W-1:0];
            3'd6: csq <= csq + prod[CSQ_W-1:0];
            default: ;
          endcase
          if (cnt == STEP_W'(LAST_MSTEP)) begin
            cnt   <= '0;
            state <= S_SQ;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQ: begin
          case (cnt)
            3'd0: begin
              if (dot[DOT_W-1]) begin
                res   <= 1'b0;
                state <= S_DONE;
              end else begin
                cnt <= cnt + 1'b1;
              end
            end
            3'd1: begin
              dsq <= prod[CMP_W-1:0];
              cnt <= cnt + 1'b1;
            end
            default: begin
              if (dsq >= lim) begin
                state <= S_NEXT;
              end else begin
                res   <= 1'b0;
                state <= S_DONE;
              end
            end
          endcase
        end
        S_NEXT: begin
          if (eidx + 1'b1 == edge_lim) begin
            res   <= 1'b1;
            state <= S_DONE;
          end else begin
            eidx  <= eidx + 1'b1;
            state <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            inside_res <= res;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PIP_ASSERT(a_norm_done, clk, rst, (state == S_DOT) |-> (fine_hi == 1'b0))
  `PIP_ASSERT(a_fetch_range, clk, rst, (state == S_FETCH) |-> (eidx < edge_lim))
  `PIP_ASSERT(a_empty_test, clk, rst, (in_valid && in_ready && func == FUNC_TEST && n_lim == '0) |=> (state == S_DONE && res))
  `PIP_ASSERT(a_done_waits, clk, rst, (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
  `PIP_ASSERT_ALL(a_reset_idle, clk, $past(rst) |-> (state == S_IDLE && !out_valid))

endmodule
